// File: src/vdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_pkg : shared types, constants and the saturating sum_add function
// Command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int TOL_WIDTH = 12;
    localparam int NUM_ATTR  = 8;
    localparam int VEC_WIDTH = 48;
    localparam int SUM_WIDTH = 60;
    localparam int CMP_WIDTH = 16;
    localparam int ACC_WIDTH = 20;

    typedef struct packed {
        logic load;     // capture input item, clear search pointer
        logic clear;    // empty the table
        logic rd;       // issue read at search pointer
        logic step;     // advance search pointer
        logic upd_hit;  // write sums to matched entry
        logic append;   // append new entry
        logic ovf;      // produce overflow result
    } vdi_cmd_t;

    typedef struct packed {
        logic more;     // search pointer below entry count
        logic hit;      // registered compare matched
        logic rd_done;  // compare data valid this cycle
        logic full;     // table full
    } vdi_sts_t;

    function automatic logic [SUM_WIDTH-1:0] sum_add(
        input logic [SUM_WIDTH-1:0] sums,
        input logic [VEC_WIDTH-1:0] vin
    );
        logic [SUM_WIDTH-1:0] res;
        logic signed [ACC_WIDTH:0] s;
        res = '0;
        for (int c = 0; c < 3; c++) begin
            s = $signed({sums[c*ACC_WIDTH + ACC_WIDTH-1], sums[c*ACC_WIDTH +: ACC_WIDTH]})
                + $signed({{(ACC_WIDTH-CMP_WIDTH+1){vin[c*CMP_WIDTH + CMP_WIDTH-1]}},
                           vin[c*CMP_WIDTH +: CMP_WIDTH]});
            if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
                res[c*ACC_WIDTH +: ACC_WIDTH] = s[ACC_WIDTH] ?
                    {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
            else
                res[c*ACC_WIDTH +: ACC_WIDTH] = s[ACC_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/vdi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_in_if / vdi_out_if : item channels
// Valid/ready channels carrying a vertex and its index result.
// ----------------------------------------------------------------------------
interface vdi_in_if #(parameter int COORD_WIDTH = 24);
    logic                   valid;
    logic                   ready;
    logic                   start_mesh;
    logic [COORD_WIDTH-1:0] pos_x;
    logic [COORD_WIDTH-1:0] pos_y;
    logic [COORD_WIDTH-1:0] pos_z;
    logic [COORD_WIDTH-1:0] tex_u;
    logic [COORD_WIDTH-1:0] tex_v;
    logic [COORD_WIDTH-1:0] norm_x;
    logic [COORD_WIDTH-1:0] norm_y;
    logic [COORD_WIDTH-1:0] norm_z;
    logic [47:0]            tangent_in;
    logic [47:0]            bitangent_in;
    modport source (output valid, start_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, tangent_in, bitangent_in, input ready);
    modport sink   (input valid, start_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, tangent_in, bitangent_in, output ready);
endinterface

interface vdi_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  vertex_index;
    logic        is_new;
    logic        overflow;
    logic [59:0] tangent_sum;
    logic [59:0] bitangent_sum;
    modport source (output valid, vertex_index, is_new, overflow, tangent_sum,
                    bitangent_sum, input ready);
    modport sink   (input valid, vertex_index, is_new, overflow, tangent_sum,
                    bitangent_sum, output ready);
endinterface

// File: src/vdi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_ctrl : search sequencer
// Walks the table one entry a cycle, then updates, appends or flags overflow.
// ----------------------------------------------------------------------------
module vdi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_start,
    output logic              in_ready,
    output logic              out_load,
    input  logic              out_busy,
    input  vdi_pkg::vdi_sts_t sts,
    output vdi_pkg::vdi_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.clear  = in_start;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one read in flight; its data is compared next cycle and the hit flag registered after
                if (sts.rd_done && sts.hit)
                    state_next = S_DONE;
                else if (sts.more)
                begin
                    cmd.rd   = 1'b1;
                    cmd.step = 1'b1;
                end
                else if (!sts.rd_done)
                    state_next = S_DONE;
                else
                    state_next = S_WAIT;
            end
            S_WAIT:
                state_next = S_DONE;
            S_DONE:
            begin
                if (!out_busy)
                begin
                    out_load = 1'b1;
                    if (sts.hit)
                        cmd.upd_hit = 1'b1;
                    else if (!sts.full)
                        cmd.append = 1'b1;
                    else
                        cmd.ovf = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: src/vdi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_dp : table datapath
// Attribute and sum memories, compare stage, saturating update.
// ----------------------------------------------------------------------------
module vdi_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [vdi_pkg::TOL_WIDTH-1:0]      tol,
    input  logic [vdi_pkg::NUM_ATTR*COORD_WIDTH-1:0] attr_in,
    input  logic [vdi_pkg::VEC_WIDTH-1:0]      tan_in,
    input  logic [vdi_pkg::VEC_WIDTH-1:0]      bit_in,
    input  vdi_pkg::vdi_cmd_t                  cmd,
    output vdi_pkg::vdi_sts_t                  sts,
    output logic [9:0]                         res_index,
    output logic                               res_new,
    output logic                               res_ovf,
    output logic [vdi_pkg::SUM_WIDTH-1:0]      res_tan,
    output logic [vdi_pkg::SUM_WIDTH-1:0]      res_bit
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AV = vdi_pkg::NUM_ATTR * COORD_WIDTH;
    localparam int SW = vdi_pkg::SUM_WIDTH;
    // difference width, wide enough for the attribute and the tolerance
    localparam int DW = ((COORD_WIDTH > vdi_pkg::TOL_WIDTH) ?
                         COORD_WIDTH : vdi_pkg::TOL_WIDTH) + 1;

    logic [AV-1:0] attr_mem [TABLE_DEPTH];
    logic [SW-1:0] tan_mem  [TABLE_DEPTH];
    logic [SW-1:0] bit_mem  [TABLE_DEPTH];

    logic [AV-1:0] attr_reg;
    logic [vdi_pkg::VEC_WIDTH-1:0] tan_reg, bit_reg;
    logic [CW-1:0] count_reg, ptr_reg, rd_addr_reg, hit_idx_reg;
    logic          rd_done_reg, hit_reg;
    logic [AV-1:0] rd_attr_reg;
    logic [SW-1:0] rd_tan_reg, rd_bit_reg;
    logic [SW-1:0] hit_tan_reg, hit_bit_reg;
    logic          close;

    always_comb
    begin
        logic signed [DW-1:0] d;
        close = 1'b1;
        for (int a = 0; a < vdi_pkg::NUM_ATTR; a++)
        begin
            d = $signed({{(DW-COORD_WIDTH){attr_reg[a*COORD_WIDTH + COORD_WIDTH-1]}},
                         attr_reg[a*COORD_WIDTH +: COORD_WIDTH]})
              - $signed({{(DW-COORD_WIDTH){rd_attr_reg[a*COORD_WIDTH + COORD_WIDTH-1]}},
                         rd_attr_reg[a*COORD_WIDTH +: COORD_WIDTH]});
            if (d[DW-1])
                d = -d;
            if (d >= $signed({{(DW-vdi_pkg::TOL_WIDTH){1'b0}}, tol}))
                close = 1'b0;
        end
    end

    assign sts.more    = (ptr_reg < count_reg);
    assign sts.hit     = hit_reg;
    assign sts.rd_done = rd_done_reg;
    assign sts.full    = (count_reg == CW'(TABLE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_done_reg <= 1'b0;
            hit_reg     <= 1'b0;
            res_new     <= 1'b0;
            res_ovf     <= 1'b0;
        end
        else
        begin
            rd_done_reg <= cmd.rd;
            if (cmd.load)
            begin
                ptr_reg <= '0;
                hit_reg <= 1'b0;
                if (cmd.clear)
                    count_reg <= '0;
            end
            if (cmd.step)
                ptr_reg <= ptr_reg + 1'b1;
            if (rd_done_reg && !hit_reg && close)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_addr_reg;
            end
            if (cmd.append)
                count_reg <= count_reg + 1'b1;
            if (cmd.upd_hit || cmd.append || cmd.ovf)
            begin
                res_new <= cmd.append;
                res_ovf <= cmd.ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            attr_reg <= attr_in;
            tan_reg  <= tan_in;
            bit_reg  <= bit_in;
        end
        if (cmd.rd)
        begin
            rd_addr_reg <= ptr_reg;
            rd_attr_reg <= attr_mem[ptr_reg[AW-1:0]];
            rd_tan_reg  <= tan_mem[ptr_reg[AW-1:0]];
            rd_bit_reg  <= bit_mem[ptr_reg[AW-1:0]];
        end
        // sums of the matched entry, taken at the compare; one more read
        // may already be in flight behind it
        if (rd_done_reg && !hit_reg && close)
        begin
            hit_tan_reg <= rd_tan_reg;
            hit_bit_reg <= rd_bit_reg;
        end
        if (cmd.upd_hit)
        begin
            tan_mem[hit_idx_reg[AW-1:0]] <= vdi_pkg::sum_add(hit_tan_reg, tan_reg);
            bit_mem[hit_idx_reg[AW-1:0]] <= vdi_pkg::sum_add(hit_bit_reg, bit_reg);
            res_index <= 10'(hit_idx_reg);
            res_tan   <= vdi_pkg::sum_add(hit_tan_reg, tan_reg);
            res_bit   <= vdi_pkg::sum_add(hit_bit_reg, bit_reg);
        end
        else if (cmd.append)
        begin
            attr_mem[count_reg[AW-1:0]] <= attr_reg;
            tan_mem[count_reg[AW-1:0]]  <= vdi_pkg::sum_add('0, tan_reg);
            bit_mem[count_reg[AW-1:0]]  <= vdi_pkg::sum_add('0, bit_reg);
            res_index <= 10'(count_reg);
            res_tan   <= vdi_pkg::sum_add('0, tan_reg);
            res_bit   <= vdi_pkg::sum_add('0, bit_reg);
        end
        else if (cmd.ovf)
        begin
            res_index <= '0;
            res_tan   <= '0;
            res_bit   <= '0;
        end
    end

endmodule

// File: src/vertex_dedup_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer : vertex indexing with tangent accumulation
// Linear search for a close stored vertex; accumulate, append or flag overflow.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | contents
//  vin       | in  | valid/ready   | start_mesh, 8 attributes, tangent, bitangent
//  vout      | out | valid/ready   | index, is_new, overflow, two sums
//  cfg       | in  | cfg_we        | match_tolerance (12 bits)
//
// One item occupies the block from its accepting cycle until its result is
// loaded: with no match the search walks every stored entry, and a match
// ends it early. The search reads one entry per cycle from one memory
// port, compares the read data in the cycle after and stops at the first
// match.
// Reset empties the table at once via the entry counter; no clearing pass.
// The result sits in an output register, so the next item is taken while
// it waits; only the final update stalls on a full output register.
module vertex_dedup_indexer #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vdi_pkg::TOL_WIDTH-1:0] cfg_wdata,
    vdi_in_if.sink                        vin,
    vdi_out_if.source                     vout
);

    logic [vdi_pkg::TOL_WIDTH-1:0] tol_reg;
    logic                          out_valid_reg;
    logic                          out_load;
    vdi_pkg::vdi_cmd_t             cmd;
    vdi_pkg::vdi_sts_t             sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= 12'd41;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (vout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign vout.valid = out_valid_reg;

    vdi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vin.valid),
        .in_start (vin.start_mesh),
        .in_ready (vin.ready),
        .out_load (out_load),
        .out_busy (out_valid_reg && !vout.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vdi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .attr_in   ({vin.norm_z, vin.norm_y, vin.norm_x, vin.tex_v, vin.tex_u,
                     vin.pos_z, vin.pos_y, vin.pos_x}),
        .tan_in    (vin.tangent_in),
        .bit_in    (vin.bitangent_in),
        .cmd       (cmd),
        .sts       (sts),
        .res_index (vout.vertex_index),
        .res_new   (vout.is_new),
        .res_ovf   (vout.overflow),
        .res_tan   (vout.tangent_sum),
        .res_bit   (vout.bitangent_sum)
    );

endmodule
